// ----- rtl/hdfe_pkg.sv -----
// Package for the HID descriptor feature extractor: item tag codes, parser
// phases, limits and the result record type. No dependencies.
`default_nettype none

package hdfe_pkg;

   localparam int MAX_RECORDS = 16;
   localparam int USAGE_LIMIT = 24;
   localparam int MAX_DEPTH   = 15;

   localparam int RECORDS_W = $clog2(MAX_RECORDS + 1);
   localparam int TALLY_W   = $clog2(USAGE_LIMIT + 1);
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

   localparam int INDEX_W    = 5;
   localparam int RSP_DATA_W = 264;
   localparam int FIFO_DEPTH = 3;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_SHORT,
      PH_LSIZE,
      PH_LSKIP
   } phase_type;

   localparam logic [7:0] TAG_LONG       = 8'hFE;
   localparam logic [7:0] TAG_SIZE_MASK  = 8'h03;
   localparam logic [7:0] TAG_MASK       = 8'hFC;
   localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
   localparam logic [7:0] TAG_USAGE      = 8'h08;
   localparam logic [7:0] TAG_LOG_MIN    = 8'h14;
   localparam logic [7:0] TAG_LOG_MAX    = 8'h24;
   localparam logic [7:0] TAG_REP_SIZE   = 8'h74;
   localparam logic [7:0] TAG_REP_COUNT  = 8'h94;
   localparam logic [7:0] TAG_REP_ID     = 8'h84;
   localparam logic [7:0] TAG_USAGE_MIN  = 8'h18;
   localparam logic [7:0] TAG_USAGE_MAX  = 8'h28;
   localparam logic [7:0] TAG_COLLECTION = 8'hA0;
   localparam logic [7:0] TAG_END_COLL   = 8'hC0;
   localparam logic [7:0] TAG_INPUT      = 8'h80;
   localparam logic [7:0] TAG_OUTPUT     = 8'h90;
   localparam logic [7:0] TAG_FEATURE    = 8'hB0;

   localparam logic [31:0] USAGE_ID_MIN = 32'h0000_001F;

   localparam logic KIND_FEATURE = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [INDEX_W-1:0]   index;
      logic [31:0]          coll_usage;
      logic [31:0]          usage_value;
      logic [31:0]          report_ident;
      logic [31:0]          report_bits;
      logic [31:0]          report_fields;
      logic [31:0]          logical_low;
      logic [31:0]          logical_high;
      logic [31:0]          feature_flags;
      logic                 is_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic [2:0] data_len(input logic [1:0] size_code);
      logic [2:0] len;
      unique case (size_code)
         2'd0:    len = 3'd0;
         2'd1:    len = 3'd1;
         2'd2:    len = 3'd2;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hid_descriptor_feature_extractor.sv -----
// Top level of the HID report descriptor feature extractor: byte parser
// feeding a small result queue. Depends on hdfe_pkg, hdfe_parser, hdfe_rsp_fifo.
//
//   channel | direction | payload
//   req_*   | in        | tdata: descriptor byte; tlast: final byte
//   rsp_*   | out       | tdata: record fields; tuser: kind; tlast: last of byte
//
// One byte is taken per cycle while req_tready is high; its state update
// finishes in that cycle and its results (zero, one or two) enter the queue
// at the same edge. A result is registered in the queue before it appears on
// rsp. A byte giving two results needs two transfers of the single rsp port,
// so input stalls there. req_tready drops when the queue holds two or more
// results. Synchronous reset clears the parser and empties the queue.
`default_nettype none

module hid_descriptor_feature_extractor
   import hdfe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // data_byte
   input  wire logic                  req_tlast,  // last_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // record_index[4:0], coll_usage, usage_value, report_ident, report_bits,
   // report_fields, logical_low, logical_high, feature_flags, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,  // result_kind
   output logic                       rsp_tlast   // is_last
);

   push_type     push;
   logic         room;
   logic         accept;
   rsp_item_type item;

   assign req_tready = room;
   assign accept     = req_tvalid & room;

   hdfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push)
   );

   hdfe_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (item)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tlast = item.is_last;
   assign rsp_tdata = {3'b000, item.feature_flags, item.logical_high, item.logical_low,
                       item.report_fields, item.report_bits, item.report_ident,
                       item.usage_value, item.coll_usage, item.index};

endmodule

`default_nettype wire

// ----- rtl/hdfe_parser.sv -----
// Descriptor byte parser: item assembly, local/global item state and result
// record generation. Depends on hdfe_pkg.
`default_nettype none

module hdfe_parser
   import hdfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output push_type        push
);

   phase_type            phase_ff, phase_in;
   logic [7:0]           tag_ff, tag_in;
   logic [8:0]           left_ff, left_in;
   logic [31:0]          accum_ff, accum_in;
   logic [15:0]          page_ff, page_in;
   logic [15:0]          first_ff, first_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic                 locked_ff, locked_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [RECORDS_W-1:0] records_ff, records_in;
   logic [31:0]          top_ff, top_in;
   logic [31:0]          usage_ff, usage_in;
   logic [31:0]          id_ff, id_in;
   logic [31:0]          size_ff, size_in;
   logic [31:0]          count_ff, count_in;
   logic [31:0]          lmin_ff, lmin_in;
   logic [31:0]          lmax_ff, lmax_in;

   logic        item_go;
   logic [7:0]  item_tag;
   logic [31:0] item_val;
   logic        clear_local;
   logic        feat_emit;
   logic [2:0]  got;
   logic [31:0] acc;
   logic [8:0]  left_dec;
   rsp_item_type feat_rec, end_rec;

   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      left_in    = left_ff;
      accum_in   = accum_ff;
      page_in    = page_ff;
      first_in   = first_ff;
      tally_in   = tally_ff;
      locked_in  = locked_ff;
      depth_in   = depth_ff;
      records_in = records_ff;
      top_in     = top_ff;
      usage_in   = usage_ff;
      id_in      = id_ff;
      size_in    = size_ff;
      count_in   = count_ff;
      lmin_in    = lmin_ff;
      lmax_in    = lmax_ff;
      item_go     = 1'b0;
      item_tag    = tag_ff;
      item_val    = accum_ff;
      clear_local = 1'b0;
      feat_emit   = 1'b0;
      got         = data_len(tag_ff[1:0]) - left_ff[2:0];
      acc         = accum_ff | (32'(data_byte) << {got[1:0], 3'b000});
      left_dec    = (left_ff != 9'd0) ? left_ff - 9'd1 : 9'd0;

      if (accept) begin
         unique case (phase_ff)
            PH_TAG: begin
               if (data_byte == TAG_LONG) begin
                  phase_in = PH_LSIZE;
               end else if ((data_byte & TAG_SIZE_MASK) == 8'h00) begin
                  item_go  = 1'b1;
                  item_tag = data_byte;
                  item_val = 32'h0;
               end else begin
                  tag_in   = data_byte;
                  left_in  = 9'(data_len(data_byte[1:0]));
                  accum_in = 32'h0;
                  phase_in = PH_SHORT;
               end
            end
            PH_SHORT: begin
               accum_in = acc;
               left_in  = left_dec;
               if (left_dec == 9'd0) begin
                  phase_in = PH_TAG;
                  item_go  = 1'b1;
                  item_val = acc;
               end
            end
            PH_LSIZE: begin
               left_in  = 9'(data_byte) + 9'd1;
               phase_in = PH_LSKIP;
            end
            PH_LSKIP: begin
               left_in = left_dec;
               if (left_dec == 9'd0) begin
                  phase_in = PH_TAG;
               end
            end
            default: phase_in = PH_TAG;
         endcase

         if (item_go) begin
            unique case (item_tag & TAG_MASK)
               TAG_USAGE_PAGE: page_in = item_val[15:0];
               TAG_USAGE: begin
                  if (!locked_ff && tally_ff < TALLY_W'(USAGE_LIMIT)) begin
                     if (item_val > USAGE_ID_MIN) begin
                        if (tally_ff == '0) begin
                           first_in = item_val[15:0];
                        end
                        tally_in = tally_ff + TALLY_W'(1);
                     end
                     usage_in = item_val;
                  end
               end
               TAG_LOG_MIN:   lmin_in  = item_val;
               TAG_LOG_MAX:   lmax_in  = item_val;
               TAG_REP_SIZE:  size_in  = item_val;
               TAG_REP_COUNT: count_in = item_val;
               TAG_REP_ID:    id_in    = item_val;
               TAG_USAGE_MIN: begin
                  first_in  = item_val[15:0];
                  locked_in = 1'b1;
               end
               TAG_USAGE_MAX: locked_in = 1'b1;
               TAG_COLLECTION: begin
                  if (depth_ff == '0) begin
                     top_in = {page_ff, first_ff};
                  end
                  if (depth_ff < DEPTH_W'(MAX_DEPTH)) begin
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
                  clear_local = 1'b1;
               end
               TAG_END_COLL: begin
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - DEPTH_W'(1);
                  end
               end
               TAG_INPUT, TAG_OUTPUT: clear_local = 1'b1;
               TAG_FEATURE: begin
                  if (records_ff < RECORDS_W'(MAX_RECORDS)) begin
                     feat_emit  = 1'b1;
                     records_in = records_ff + RECORDS_W'(1);
                  end
                  clear_local = 1'b1;
               end
               default: clear_local = 1'b0;
            endcase
            if (clear_local) begin
               tally_in  = '0;
               first_in  = 16'h0;
               locked_in = 1'b0;
            end
         end
      end

      feat_rec.kind          = KIND_FEATURE;
      feat_rec.index         = INDEX_W'(records_ff);
      feat_rec.coll_usage    = top_ff;
      feat_rec.usage_value   = usage_ff;
      feat_rec.report_ident  = id_ff;
      feat_rec.report_bits   = size_ff;
      feat_rec.report_fields = count_ff;
      feat_rec.logical_low   = lmin_ff;
      feat_rec.logical_high  = lmax_ff;
      feat_rec.feature_flags = item_val;
      feat_rec.is_last       = !last_byte;

      end_rec               = '0;
      end_rec.kind          = KIND_END;
      end_rec.index         = INDEX_W'(records_in);
      end_rec.is_last       = 1'b1;

      push.count  = {1'b0, feat_emit} + {1'b0, accept & last_byte};
      push.first  = feat_emit ? feat_rec : end_rec;
      push.second = end_rec;

      // end of descriptor: everything back to its reset value
      if (accept && last_byte) begin
         phase_in   = PH_TAG;
         tag_in     = 8'h0;
         left_in    = 9'd0;
         accum_in   = 32'h0;
         page_in    = 16'h0;
         first_in   = 16'h0;
         tally_in   = '0;
         locked_in  = 1'b0;
         depth_in   = '0;
         records_in = '0;
         top_in     = 32'h0;
         usage_in   = 32'h0;
         id_in      = 32'h0;
         size_in    = 32'h0;
         count_in   = 32'h0;
         lmin_in    = 32'h0;
         lmax_in    = 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         tag_ff     <= 8'h0;
         left_ff    <= 9'd0;
         accum_ff   <= 32'h0;
         page_ff    <= 16'h0;
         first_ff   <= 16'h0;
         tally_ff   <= '0;
         locked_ff  <= 1'b0;
         depth_ff   <= '0;
         records_ff <= '0;
         top_ff     <= 32'h0;
         usage_ff   <= 32'h0;
         id_ff      <= 32'h0;
         size_ff    <= 32'h0;
         count_ff   <= 32'h0;
         lmin_ff    <= 32'h0;
         lmax_ff    <= 32'h0;
      end else begin
         phase_ff   <= phase_in;
         tag_ff     <= tag_in;
         left_ff    <= left_in;
         accum_ff   <= accum_in;
         page_ff    <= page_in;
         first_ff   <= first_in;
         tally_ff   <= tally_in;
         locked_ff  <= locked_in;
         depth_ff   <= depth_in;
         records_ff <= records_in;
         top_ff     <= top_in;
         usage_ff   <= usage_in;
         id_ff      <= id_in;
         size_ff    <= size_in;
         count_ff   <= count_in;
         lmin_ff    <= lmin_in;
         lmax_ff    <= lmax_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hdfe_rsp_fifo.sv -----
// Three-entry result queue taking up to two records per cycle and handing
// out one per transfer. Depends on hdfe_pkg.
`default_nettype none

module hdfe_rsp_fifo
   import hdfe_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire push_type push,
   output logic       room,
   output logic       out_valid,
   input  wire logic  out_ready,
   output rsp_item_type out_item
);

   rsp_item_type entry_ff [FIFO_DEPTH];
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] wptr_next;

   function automatic logic [1:0] next_slot(input logic [1:0] ptr);
      return (ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
   endfunction

   assign pop       = out_valid & out_ready;
   assign out_valid = (cnt_ff != 2'd0);
   assign room      = (cnt_ff <= 2'd1);
   assign out_item  = entry_ff[rptr_ff];
   assign wptr_next = next_slot(wptr_ff);

   always_comb begin
      cnt_in  = cnt_ff + push.count - {1'b0, pop};
      rptr_in = pop ? next_slot(rptr_ff) : rptr_ff;
      unique case (push.count)
         2'd1:    wptr_in = wptr_next;
         2'd2:    wptr_in = next_slot(wptr_next);
         default: wptr_in = wptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 2'd0;
         rptr_ff <= 2'd0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hdfe_checker.sv -----
// Port-level checks for the HID descriptor feature extractor, bound to the
// top level. Depends on hdfe_pkg.
`default_nettype none

module hdfe_checker
   import hdfe_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no result after final descriptor byte");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast)
      else $error("end result not marked last");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tdata[RSP_DATA_W-1:INDEX_W] == '0)
      else $error("end result carries record data");

endmodule

bind hid_descriptor_feature_extractor hdfe_checker u_hdfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- dv/hdfe_record_checker.sv -----
// Checker for the HID descriptor feature extractor: watches the byte and result
// streams, predicts the feature and end records and compares them field by field.
// Depends on hdfe_pkg.
module hdfe_record_checker
   import hdfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type            phase;
   logic [7:0]           cur_tag;
   logic [8:0]           bytes_left;
   logic [31:0]          accum;
   logic [15:0]          page;
   logic [15:0]          first_use;
   logic [TALLY_W-1:0]   tally;
   logic                 locked;
   logic [DEPTH_W-1:0]   depth;
   logic [31:0]          top_use;
   logic [31:0]          last_usage;
   logic [31:0]          rep_id;
   logic [31:0]          rep_size;
   logic [31:0]          rep_count;
   logic [31:0]          log_min;
   logic [31:0]          log_max;
   logic [RECORDS_W-1:0] made_count;

   rsp_item_type expected_records[$];
   rsp_item_type byte_records[2];
   int           byte_record_count;
   int           fail_count = 0;

   string word_names[8] = '{"coll_usage", "usage_value", "report_ident", "report_bits",
                            "report_fields", "logical_low", "logical_high",
                            "feature_flags"};

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic [8:0] item_len(input logic [1:0] code);
      return (code == 2'd3) ? 9'd4 : {7'd0, code};
   endfunction

   task automatic clear_parser();
      phase      = PH_TAG;
      cur_tag    = '0;
      bytes_left = '0;
      accum      = '0;
      page       = '0;
      first_use  = '0;
      tally      = '0;
      locked     = 1'b0;
      depth      = '0;
      top_use    = '0;
      last_usage = '0;
      rep_id     = '0;
      rep_size   = '0;
      rep_count  = '0;
      log_min    = '0;
      log_max    = '0;
      made_count = '0;
   endtask

   task automatic apply_item(input logic [7:0] tag, input logic [31:0] val);
      logic         drop_locals;
      rsp_item_type rec;
      drop_locals = 1'b0;
      case (tag & TAG_MASK)
         TAG_USAGE_PAGE: page = val[15:0];
         TAG_USAGE: begin
            if (!locked && tally < USAGE_LIMIT) begin
               if (val > USAGE_ID_MIN) begin
                  if (tally == 0) first_use = val[15:0];
                  tally = tally + 1'b1;
               end
               last_usage = val;
            end
         end
         TAG_LOG_MIN:   log_min   = val;
         TAG_LOG_MAX:   log_max   = val;
         TAG_REP_SIZE:  rep_size  = val;
         TAG_REP_COUNT: rep_count = val;
         TAG_REP_ID:    rep_id    = val;
         TAG_USAGE_MIN: begin
            first_use = val[15:0];
            locked    = 1'b1;
         end
         TAG_USAGE_MAX: locked = 1'b1;
         TAG_COLLECTION: begin
            if (depth == 0) top_use = {page, first_use};
            if (depth < MAX_DEPTH) depth = depth + 1'b1;
            drop_locals = 1'b1;
         end
         TAG_END_COLL: begin
            if (depth != 0) depth = depth - 1'b1;
         end
         TAG_INPUT, TAG_OUTPUT: drop_locals = 1'b1;
         TAG_FEATURE: begin
            if (made_count < MAX_RECORDS) begin
               rec               = '0;
               rec.kind          = KIND_FEATURE;
               rec.index         = INDEX_W'(made_count);
               rec.coll_usage    = top_use;
               rec.usage_value   = last_usage;
               rec.report_ident  = rep_id;
               rec.report_bits   = rep_size;
               rec.report_fields = rep_count;
               rec.logical_low   = log_min;
               rec.logical_high  = log_max;
               rec.feature_flags = val;
               byte_records[byte_record_count] = rec;
               byte_record_count++;
               made_count = made_count + 1'b1;
            end
            drop_locals = 1'b1;
         end
         default: ;
      endcase
      if (drop_locals) begin
         tally     = '0;
         first_use = '0;
         locked    = 1'b0;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      logic [8:0]   got;
      rsp_item_type rec;
      byte_record_count = 0;
      case (phase)
         PH_TAG: begin
            if (b == TAG_LONG) begin
               phase = PH_LSIZE;
            end else if ((b & TAG_SIZE_MASK) == 8'd0) begin
               apply_item(b, 32'd0);
            end else begin
               cur_tag    = b;
               bytes_left = item_len(b[1:0]);
               accum      = '0;
               phase      = PH_SHORT;
            end
         end
         PH_SHORT: begin
            got   = item_len(cur_tag[1:0]) - bytes_left;
            accum = accum | ({24'd0, b} << (8 * got[1:0]));
            if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) begin
               phase = PH_TAG;
               apply_item(cur_tag, accum);
            end
         end
         PH_LSIZE: begin
            bytes_left = {1'b0, b} + 9'd1;
            phase      = PH_LSKIP;
         end
         default: begin
            if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) phase = PH_TAG;
         end
      endcase
      if (last) begin
         rec       = '0;
         rec.kind  = KIND_END;
         rec.index = INDEX_W'(made_count);
         byte_records[byte_record_count] = rec;
         byte_record_count++;
         clear_parser();
      end
      if (byte_record_count > 0) byte_records[byte_record_count - 1].is_last = 1'b1;
      for (int i = 0; i < byte_record_count; i++) expected_records.push_back(byte_records[i]);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      logic [31:0]  want_words[8];
      if (reset) begin
         clear_parser();
         expected_records.delete();
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_records.size() == 0) begin
               $error("result_kind %0d index %0d transfer with no record expected",
                      rsp_tuser, rsp_tdata[INDEX_W-1:0]);
               fail_count++;
            end else begin
               want       = expected_records.pop_front();
               want_words = '{want.coll_usage, want.usage_value, want.report_ident,
                              want.report_bits, want.report_fields, want.logical_low,
                              want.logical_high, want.feature_flags};
               compare_field("result_kind", {31'd0, want.kind}, {31'd0, rsp_tuser});
               compare_field("record_index", {27'd0, want.index},
                             {27'd0, rsp_tdata[INDEX_W-1:0]});
               for (int k = 0; k < 8; k++)
                  compare_field(word_names[k], want_words[k], rsp_tdata[INDEX_W + 32*k +: 32]);
               compare_field("is_last", {31'd0, want.is_last}, {31'd0, rsp_tlast});
            end
         end
      end
      outstanding <= expected_records.size();
      mismatches  <= fail_count;
   end

endmodule

// ----- dv/tb_hid_descriptor_feature_extractor.sv -----
// Top of the HID descriptor feature extractor testbench: clock, reset, descriptor
// byte stimulus, result back-pressure, watchdog and verdict.
// Depends on hdfe_pkg, hid_descriptor_feature_extractor and hdfe_record_checker.
module tb_hid_descriptor_feature_extractor
   import hdfe_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES   = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int   mismatches;
   int   outstanding;
   int   stall_left   = 0;
   int   idle_cycles  = 0;
   logic stall_enable = 1'b0;
   logic gaps_on      = 1'b0;

   logic [7:0] desc_bytes[$];
   logic [7:0] item_tags[14] = '{TAG_USAGE_PAGE, TAG_USAGE, TAG_LOG_MIN, TAG_LOG_MAX,
                                 TAG_REP_SIZE, TAG_REP_COUNT, TAG_REP_ID, TAG_USAGE_MIN,
                                 TAG_USAGE_MAX, TAG_COLLECTION, TAG_END_COLL, TAG_INPUT,
                                 TAG_OUTPUT, TAG_FEATURE};

   hid_descriptor_feature_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   hdfe_record_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0:       v = 32'd0;
         1:       v = 32'hFFFF_FFFF;
         2:       v = $urandom_range(0, 31);
         3:       v = $urandom_range(32, 300);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic add_short(input logic [7:0] tag, input logic [1:0] code,
                            input logic [31:0] val);
      int len;
      len = (code == 2'd3) ? 4 : int'(code);
      desc_bytes.push_back(tag | {6'd0, code});
      for (int i = 0; i < len; i++) desc_bytes.push_back(val[8*i +: 8]);
   endtask

   // mode 1 floods features, 2 floods counted usages, 3 nests collections
   task automatic add_random_item(input int mode);
      int         sel;
      int         len;
      logic [1:0] code;
      logic [5:0] odd_tag;
      logic [31:0] val;
      sel     = $urandom_range(0, 19);
      code    = 2'($urandom_range(0, 3));
      odd_tag = 6'($urandom_range(0, 63));
      val     = pick_value();
      if (mode == 2 && $urandom_range(0, 99) < 85) begin
         add_short(TAG_USAGE, 2'd2, $urandom_range(32, 65535));
      end else if (mode == 1 && $urandom_range(0, 99) < 60) begin
         add_short(TAG_FEATURE, code, val);
      end else if (mode == 3 && $urandom_range(0, 99) < 60) begin
         add_short(TAG_COLLECTION, code, val);
      end else if (sel < 14) begin
         add_short(item_tags[sel], code, val);
      end else if (sel < 16) begin
         add_short({odd_tag, 2'b00}, code, val);
      end else if (sel == 16) begin
         len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 3);
         desc_bytes.push_back(TAG_LONG);
         desc_bytes.push_back(8'(len));
         desc_bytes.push_back(8'($urandom));
         repeat (len) desc_bytes.push_back(8'($urandom));
      end else if (sel == 17) begin
         desc_bytes.push_back(8'($urandom));
      end else begin
         add_short(TAG_USAGE, code, val);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_descriptor();
      foreach (desc_bytes[i]) send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
      desc_bytes.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int random_bytes;
      int mode;
      int n_items;
      int cut;
      repeat (2) @(posedge clock);
      reset        <= 1'b0;
      gaps_on       = 1'b1;
      stall_enable <= 1'b1;

      // page, small and counted usages, collection, 4-byte logical min,
      // usage range lock, feature, end collection below depth zero, long item,
      // unknown tag, input, output, feature on the final byte
      desc_bytes = {8'h05, 8'h0D, 8'h09, 8'h05, 8'h0A, 8'h34, 8'h12, 8'hA0,
                    8'h17, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h19, 8'h40, 8'h09, 8'h50,
                    8'h29, 8'h60, 8'hB1, 8'h02, 8'hC0, 8'hC0, 8'hFE, 8'h00, 8'hAA,
                    8'hF0, 8'h80, 8'h90, 8'hB0};
      send_descriptor();
      desc_bytes = {8'h96, 8'h00};
      send_descriptor();
      desc_bytes = {8'hFE, 8'h05, 8'h01};
      send_descriptor();
      desc_bytes = {8'h00};
      send_descriptor();
      drain();

      random_bytes = 0;
      for (int d = 0; random_bytes < RANDOM_BYTES; d++) begin
         if (d < 3) mode = d + 1;
         else mode = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
         n_items = (mode != 0) ? $urandom_range(30, 45) : $urandom_range(1, 25);
         if (random_bytes > RANDOM_BYTES - 60) begin
            gaps_on       = 1'b0;
            stall_enable <= 1'b0;
         end else begin
            gaps_on       = ($urandom_range(0, 3) != 0);
            stall_enable <= ($urandom_range(0, 3) != 0);
         end
         repeat (n_items) add_random_item(mode);
         if ($urandom_range(0, 5) == 0) begin
            cut        = $urandom_range(1, desc_bytes.size());
            desc_bytes = desc_bytes[0:cut-1];
         end
         random_bytes += desc_bytes.size();
         send_descriptor();
         if (d == 5) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
